/* rtl/core/eps_pkg.sv */
// ----------------------------------------------------------------------------
// eps_pkg: shared definitions for the exponential-pitch sine oscillator
// Holds the controller state and command types, the register indexes, the
// fixed-point constants and the elaboration-time table generators.
// ----------------------------------------------------------------------------
package eps_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int EXP_TABLE_BITS_DEF  = 8;
    localparam int PHASE_BITS_DEF      = 32;

    localparam logic [31:0] C4_HZ_Q16         = 32'd17145895;
    localparam logic [63:0] LN2_Q30           = 64'd744261118;
    localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;
    localparam logic [63:0] ONE_Q30           = 64'd1073741824;
    localparam logic [63:0] AMP_Q11           = 64'd10240;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd89478;

    localparam logic signed [17:0] PITCH_MIN    = -18'sd8192;
    localparam logic signed [17:0] PITCH_MAX    = 18'sd8192;
    localparam logic signed [17:0] PITCH_OFFSET = 18'sd8192;

    localparam int CFG_DATA_BITS = 32;
    localparam int KNOB_BITS     = 17;

    // Series divisors are applied as ceil(2^48 / d), which gives exact
    // quotients for every dividend the table series can produce.
    localparam int          RECIP_SHIFT = 48;
    localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;

    localparam logic [63:0] EXP_RECIP [16] = '{
        (RECIP_ONE + 64'd0) / 64'd1,    (RECIP_ONE + 64'd1) / 64'd2,
        (RECIP_ONE + 64'd2) / 64'd3,    (RECIP_ONE + 64'd3) / 64'd4,
        (RECIP_ONE + 64'd4) / 64'd5,    (RECIP_ONE + 64'd5) / 64'd6,
        (RECIP_ONE + 64'd6) / 64'd7,    (RECIP_ONE + 64'd7) / 64'd8,
        (RECIP_ONE + 64'd8) / 64'd9,    (RECIP_ONE + 64'd9) / 64'd10,
        (RECIP_ONE + 64'd10) / 64'd11,  (RECIP_ONE + 64'd11) / 64'd12,
        (RECIP_ONE + 64'd12) / 64'd13,  (RECIP_ONE + 64'd13) / 64'd14,
        (RECIP_ONE + 64'd14) / 64'd15,  (RECIP_ONE + 64'd15) / 64'd16
    };

    localparam logic [63:0] SINE_RECIP [10] = '{
        (RECIP_ONE + 64'd5) / 64'd6,      (RECIP_ONE + 64'd19) / 64'd20,
        (RECIP_ONE + 64'd41) / 64'd42,    (RECIP_ONE + 64'd71) / 64'd72,
        (RECIP_ONE + 64'd109) / 64'd110,  (RECIP_ONE + 64'd155) / 64'd156,
        (RECIP_ONE + 64'd209) / 64'd210,  (RECIP_ONE + 64'd271) / 64'd272,
        (RECIP_ONE + 64'd341) / 64'd342,  (RECIP_ONE + 64'd419) / 64'd420
    };

    typedef enum logic [0:0] {
        CFG_PITCH_KNOB    = 1'b0,
        CFG_SAMPLE_PERIOD = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_PHASE,
        ST_SINE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic phase;
        logic sine;
        logic out_load;
    } t_dp_cmd;

    // Quotient of n by the divisor whose reciprocal is given, for n below 2^38.
    function automatic logic [63:0] div_by_recip(input logic [63:0] n,
                                                 input logic [63:0] recip);
        logic [127:0] p;
        p = 128'(n) * 128'(recip);
        return p[RECIP_SHIFT +: 64];
    endfunction

    // Entry i of the exp2 table: 2^(i / 2^bits) in Q1.30, by a Taylor series.
    function automatic logic [31:0] exp_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        t    = (64'(i) * LN2_Q30) >> bits;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= 16; k++) begin
            term = div_by_recip((term * t) >> 30, EXP_RECIP[4'(k - 1)]);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

    // Entry i of the quarter-wave table, scaled to five volts in Q3.11.
    function automatic logic [13:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(i) * HALF_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 10; k++) begin
            term = div_by_recip((term * x2) >> 30, SINE_RECIP[4'(k - 1)]);
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ((64'(sum) * AMP_Q11) + (64'd1 << 29)) >> 30;
        if (v > AMP_Q11) begin
            v = AMP_Q11;
        end
        return v[13:0];
    endfunction

endpackage

/* rtl/core/eps_in_if.sv */
// ----------------------------------------------------------------------------
// eps_in_if: sample tick channel
// Carries one pitch control voltage word per sample tick.
// ----------------------------------------------------------------------------
interface eps_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_cv;

    modport source (output valid, output pitch_cv, input ready);
    modport sink (input valid, input pitch_cv, output ready);
endinterface

/* rtl/core/eps_out_if.sv */
// ----------------------------------------------------------------------------
// eps_out_if: oscillator result channel
// Carries one sine sample and the blink light per sample tick.
// ----------------------------------------------------------------------------
interface eps_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] sine_out;
    logic               light_on;

    modport source (output valid, output sine_out, output light_on, input ready);
    modport sink (input valid, input sine_out, input light_on, output ready);
endinterface

/* rtl/core/eps_ctrl.sv */
// ----------------------------------------------------------------------------
// eps_ctrl: oscillator sequencer
// Steps each accepted word through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module eps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output eps_pkg::t_dp_cmd o_cmd
);
    import eps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_PHASE;
            ST_PHASE: n_state = ST_SINE;
            ST_SINE:  n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL1:  o_cmd.mul1 = 1'b1;
            ST_MUL2:  o_cmd.mul2 = 1'b1;
            ST_PHASE: o_cmd.phase = 1'b1;
            ST_SINE:  o_cmd.sine = 1'b1;
            ST_OUT:   o_cmd.out_load = !r_out_valid || i_out_ready;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("A waiting result word was overwritten.");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##5 (r_state == ST_OUT))
        else $error("An accepted word did not reach the output step in time.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("A second word was accepted while one was in flight.");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("A loaded result word was not presented.");

endmodule

/* rtl/core/eps_datapath.sv */
// ----------------------------------------------------------------------------
// eps_datapath: oscillator arithmetic
// Pitch clamp, exp2 table, shared multiplier, phase accumulators and the
// quarter-wave sine table, each step enabled by the sequencer.
// ----------------------------------------------------------------------------
module eps_datapath #(
    parameter int SINE_TABLE_BITS = eps_pkg::SINE_TABLE_BITS_DEF,
    parameter int EXP_TABLE_BITS  = eps_pkg::EXP_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = eps_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  eps_pkg::t_dp_cmd                    i_cmd,
    input  logic                                i_cfg_we,
    input  eps_pkg::t_cfg_reg                   i_cfg_index,
    input  logic [eps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic signed [15:0]                  i_pitch_cv,
    output logic signed [14:0]                  o_sine_out,
    output logic                                o_light_on
);
    import eps_pkg::*;

    localparam int EXP_SIZE  = 1 << EXP_TABLE_BITS;
    localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;

    logic [KNOB_BITS-1:0]     r_knob;
    logic [31:0]              r_period;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [31:0]              r_blink;
    logic [31:0]              r_exp;
    logic [3:0]               r_oct;
    logic [63:0]              r_prod;
    logic [13:0]              r_sine_q;
    logic                     r_neg;
    logic signed [14:0]       r_sine_out;
    logic                     r_light_on;

    logic [31:0]              w_exp_rom [EXP_SIZE];
    logic [13:0]              w_sine_rom [SINE_SIZE + 1];

    logic signed [17:0]       w_pitch_sum;
    logic signed [17:0]       w_pitch;
    logic [14:0]              w_q;
    logic [EXP_TABLE_BITS+10:0] w_frac_ext;
    logic [EXP_TABLE_BITS-1:0] w_exp_addr;
    logic [31:0]              w_mul_a;
    logic [31:0]              w_mul_b;
    logic [63:0]              w_product;
    logic [4:0]               w_shamt;
    logic [63:0]              w_shifted;
    logic [PHASE_BITS-1:0]    w_inc;
    logic [1:0]               w_quad;
    logic [SINE_TABLE_BITS-1:0] w_raw_idx;
    logic [SINE_TABLE_BITS:0] w_sine_addr;

    for (genvar g = 0; g < EXP_SIZE; g++) begin : g_exp_rom
        assign w_exp_rom[g] = exp_entry(g, EXP_TABLE_BITS);
    end

    for (genvar g = 0; g <= SINE_SIZE; g++) begin : g_sine_rom
        assign w_sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob   <= '0;
            r_period <= SAMPLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PITCH_KNOB:    r_knob <= i_cfg_data[KNOB_BITS-1:0];
                CFG_SAMPLE_PERIOD: r_period <= i_cfg_data[31:0];
                default: begin
                    r_knob   <= r_knob;
                    r_period <= r_period;
                end
            endcase
        end
    end

    always_comb begin
        w_pitch_sum = 18'(i_pitch_cv) + $signed({6'd0, r_knob[KNOB_BITS-1:5]});
        if (w_pitch_sum < PITCH_MIN) begin
            w_pitch = PITCH_MIN;
        end else if (w_pitch_sum > PITCH_MAX) begin
            w_pitch = PITCH_MAX;
        end else begin
            w_pitch = w_pitch_sum;
        end
    end

    assign w_q        = 15'(w_pitch + PITCH_OFFSET);
    assign w_frac_ext = {w_q[10:0], {EXP_TABLE_BITS{1'b0}}};
    assign w_exp_addr = w_frac_ext[EXP_TABLE_BITS+10:11];

    assign w_mul_a   = i_cmd.mul2 ? r_prod[61:30] : r_exp;
    assign w_mul_b   = i_cmd.mul2 ? r_period : C4_HZ_Q16;
    assign w_product = 64'(w_mul_a) * 64'(w_mul_b);

    assign w_shamt   = 5'd20 - {1'b0, r_oct};
    assign w_shifted = r_prod >> w_shamt;
    assign w_inc     = w_shifted[31 -: PHASE_BITS];

    assign w_quad      = r_phase[PHASE_BITS-1 -: 2];
    assign w_raw_idx   = r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_sine_addr = w_quad[0] ? ((SINE_TABLE_BITS+1)'(SINE_SIZE) - {1'b0, w_raw_idx})
                                   : {1'b0, w_raw_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_blink <= '0;
        end else begin
            if (i_cmd.load) begin
                r_blink <= r_blink + r_period;
            end
            if (i_cmd.phase) begin
                r_phase <= r_phase + w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exp <= w_exp_rom[w_exp_addr];
            r_oct <= w_q[14:11];
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_prod <= w_product;
        end
        if (i_cmd.sine) begin
            r_sine_q <= w_sine_rom[w_sine_addr];
            r_neg    <= w_quad[1];
        end
        if (i_cmd.out_load) begin
            r_sine_out <= r_neg ? -$signed({1'b0, r_sine_q}) : $signed({1'b0, r_sine_q});
            r_light_on <= !r_blink[31];
        end
    end

    assign o_sine_out = r_sine_out;
    assign o_light_on = r_light_on;

endmodule

/* rtl/core/exp_pitch_sine_oscillator.sv */
// ----------------------------------------------------------------------------
// exp_pitch_sine_oscillator: exponential-pitch sine oscillator
// Takes one pitch control voltage word per sample tick and returns one sine
// sample and the one-second blink light.
// ----------------------------------------------------------------------------
// Each accepted word passes six steps: the acceptance edge clamps the pitch
// and reads the exp2 table, then come two passes through the single shared
// 32x32 multiplier (base frequency, then times the sample period), one step
// for the octave shift and phase update, one for the registered sine table
// read, and one to load the output register, which waits while an earlier
// result is still held and not taken. A new word is accepted in the cycle
// after the result is loaded, even while that result still waits to be taken,
// so words are taken one at a time.
// Configuration writes take effect at once and need no clearing pass.
module exp_pitch_sine_oscillator #(
    parameter int SINE_TABLE_BITS = eps_pkg::SINE_TABLE_BITS_DEF,
    parameter int EXP_TABLE_BITS  = eps_pkg::EXP_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = eps_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    eps_in_if.sink                            i_in,
    eps_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  eps_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [eps_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import eps_pkg::*;

    t_dp_cmd            w_cmd;
    logic               w_in_ready;
    logic               w_out_valid;
    logic signed [14:0] w_sine_out;
    logic               w_light_on;

    eps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    eps_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .EXP_TABLE_BITS  (EXP_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pitch_cv  (i_in.pitch_cv),
        .o_sine_out  (w_sine_out),
        .o_light_on  (w_light_on)
    );

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = w_out_valid;
    assign o_out.sine_out = w_sine_out;
    assign o_out.light_on = w_light_on;

endmodule

/* tb/eps_sample_checker.sv */
// ----------------------------------------------------------------------------
// eps_sample_checker: result predictor and comparator for the oscillator
// Watches the pitch word channel, the result channel and the register write
// port. For every accepted pitch word it steps its own copy of the oscillator
// and queues the expected sine word. Each accepted result word is then
// compared, field by field, with the oldest queued expectation.
// ----------------------------------------------------------------------------
module eps_sample_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    eps_in_if                                 in_mon,
    eps_out_if                                out_mon,
    input  logic                              i_cfg_we,
    input  eps_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [eps_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    import eps_pkg::*;

    localparam int SINE_BITS = SINE_TABLE_BITS_DEF;
    localparam int EXP_BITS  = EXP_TABLE_BITS_DEF;

    typedef struct packed {
        logic signed [14:0] sine;
        logic               light;
    } t_osc_word;

    logic [31:0] exp2_rom [0:(1 << EXP_BITS) - 1];
    logic [13:0] quarter_rom [0:(1 << SINE_BITS)];

    logic [KNOB_BITS-1:0] knob;
    logic [31:0]          period;
    logic [31:0]          osc_phase;
    logic [31:0]          blink_phase;
    t_osc_word            expected_q [$];

    initial begin
        logic [63:0]        t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        total;
        logic [63:0]        v;
        logic signed [63:0] acc;
        for (int i = 0; i < (1 << EXP_BITS); i++) begin
            t     = (64'(i) * LN2_Q30) >> EXP_BITS;
            term  = ONE_Q30;
            total = ONE_Q30;
            for (int k = 1; k <= 16; k++) begin
                term  = ((term * t) >> 30) / 64'(k);
                total = total + term;
            end
            exp2_rom[EXP_BITS'(i)] = total[31:0];
        end
        for (int i = 0; i <= (1 << SINE_BITS); i++) begin
            x    = (64'(i) * HALF_PI_Q30) >> SINE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = $signed(x);
            for (int k = 1; k <= 10; k++) begin
                term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = ((64'(acc) * AMP_Q11) + (64'd1 << 29)) >> 30;
            if (v > AMP_Q11) begin
                v = AMP_Q11;
            end
            quarter_rom[(SINE_BITS + 1)'(i)] = v[13:0];
        end
    end

    function automatic t_osc_word advance_oscillator(input logic signed [15:0] cv);
        int                  pitch;
        int                  q;
        int                  oct;
        int                  frac;
        logic [EXP_BITS-1:0] idx;
        logic [63:0]         fbase;
        logic [63:0]         prod;
        logic [1:0]          quad;
        logic [SINE_BITS:0]  sidx;
        logic signed [14:0]  mag;
        t_osc_word           res;
        pitch = int'(cv) + int'(knob >> 5);
        if (pitch < -8192) begin
            pitch = -8192;
        end
        if (pitch > 8192) begin
            pitch = 8192;
        end
        q     = pitch + 8192;
        oct   = q >> 11;
        frac  = q & 2047;
        idx   = EXP_BITS'((frac << EXP_BITS) >> 11);
        fbase = (64'(C4_HZ_Q16) * 64'(exp2_rom[idx])) >> 30;
        prod  = (fbase * 64'(period)) >> (20 - oct);
        osc_phase = osc_phase + prod[31:0];
        quad = osc_phase[31:30];
        sidx = {1'b0, osc_phase[29 -: SINE_BITS]};
        if (quad[0]) begin
            sidx = (SINE_BITS + 1)'(1 << SINE_BITS) - sidx;
        end
        mag = $signed({1'b0, quarter_rom[sidx]});
        res.sine = quad[1] ? -mag : mag;
        blink_phase = blink_phase + period;
        res.light = ~blink_phase[31];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_osc_word want;
        if (!i_rst_n) begin
            knob         = '0;
            period       = SAMPLE_PERIOD_RST;
            osc_phase    = '0;
            blink_phase  = '0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PITCH_KNOB: begin
                        knob = i_cfg_data[KNOB_BITS-1:0];
                    end
                    CFG_SAMPLE_PERIOD: begin
                        period = i_cfg_data[31:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                expected_q.push_back(advance_oscillator(in_mon.pitch_cv));
            end
            if (out_mon.valid && out_mon.ready) begin
                o_checked++;
                if (expected_q.size() == 0) begin
                    $error("Unexpected sine word: sine_out %0d, light_on %0b",
                           out_mon.sine_out, out_mon.light_on);
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (out_mon.sine_out !== want.sine) begin
                        $error("sine_out: expected %0d, actual %0d", want.sine,
                               out_mon.sine_out);
                        o_fail_count++;
                    end
                    if (out_mon.light_on !== want.light) begin
                        $error("light_on: expected %0b, actual %0b", want.light,
                               out_mon.light_on);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for the exponential-pitch sine oscillator
// Sends corner pitch words under several knob and sample period settings,
// then phases of random pitch words with random gaps on the sending side and
// random stalls on the receiving side. A separate checker predicts and
// compares every result word; this module drives stimulus and reports.
// ----------------------------------------------------------------------------
module tb;
    import eps_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    t_cfg_reg                 cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       fail_count;
    int                       pending;
    int                       checked;
    int                       words_sent = 0;
    int                       reg_writes = 0;
    int                       stall_left = 0;
    bit                       sink_stalls = 1'b0;

    eps_in_if  in_ch ();
    eps_out_if out_ch ();

    exp_pitch_sine_oscillator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    eps_sample_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [15:0] pick_cv();
        int v;
        if ($urandom_range(0, 99) < 40) begin
            return 16'($urandom);
        end
        v = $urandom_range(0, 18000) - 9000;
        return 16'(v);
    endfunction

    always @(negedge i_clk) begin
        if (sink_stalls && stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = gap_len();
        end
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(input logic signed [15:0] cv);
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.pitch_cv <= cv;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic idle_in(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid    <= 1'b0;
            in_ch.pitch_cv <= 16'($urandom);
        end
    endtask

    task automatic wait_drained();
        idle_in(1);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        reg_writes++;
    endtask

    initial begin
        int                 corner_cv [14];
        logic [KNOB_BITS-1:0] knob;
        logic [31:0]        period;
        corner_cv = '{0, 32767, -32768, -8192, 8192, -8193, 8193, -1, 1, 2047, 2048,
                      -2048, 21845, -21846};
        in_ch.valid    = 1'b0;
        in_ch.pitch_cv = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PITCH_KNOB;
        cfg_data       = '0;
        i_rst_n        = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_cv[i]) begin
            send_word(16'(corner_cv[i]));
        end
        wait_drained();
        write_reg(CFG_PITCH_KNOB, 32'hFFFF_FFFF);
        write_reg(CFG_SAMPLE_PERIOD, 32'd0);
        send_word(16'sd0);
        send_word(16'sd32767);
        send_word(-16'sd32768);
        wait_drained();
        write_reg(CFG_PITCH_KNOB, 32'd65536);
        write_reg(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        send_word(16'sd8192);
        send_word(-16'sd32768);
        send_word(16'sd100);

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0: knob = '0;
                1: knob = 17'd65536;
                2: knob = '1;
                default: knob = 17'($urandom_range(0, 131071));
            endcase
            case (ph)
                0: period = SAMPLE_PERIOD_RST;
                1: period = 32'hFFFF_FFFF;
                2: period = 32'd1;
                3: period = 32'd0;
                4: period = 32'($urandom_range(1, 65535));
                default: period = $urandom;
            endcase
            write_reg(CFG_PITCH_KNOB, {15'($urandom), knob});
            write_reg(CFG_SAMPLE_PERIOD, period);
            sink_stalls = (ph % 3 != 1);
            for (int n = 0; n < 56; n++) begin
                if (ph == 2 && n == 28) begin
                    wait_drained();
                end
                send_word(pick_cv());
                if (ph % 3 != 0) begin
                    idle_in(gap_len());
                end
            end
        end

        idle_in(1);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d pitch words, %0d register writes and %0d checked sine words.",
                 words_sent, reg_writes, checked);
        $display("Knob went from zero to all 17 bits, sample period from zero to all ones.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* exp_pitch_sine_oscillator.f */
rtl/core/eps_pkg.sv
rtl/core/eps_in_if.sv
rtl/core/eps_out_if.sv
rtl/core/eps_ctrl.sv
rtl/core/eps_datapath.sv
rtl/core/exp_pitch_sine_oscillator.sv
tb/eps_sample_checker.sv
tb/tb.sv
